// File: rtl/core/sop_rk4_pkg.sv
// Shared types, constants and the micro-program of the RK4 plant step core.
// Used by the sequencer, the multiply unit and the port checker; no dependencies.
package sop_rk4_pkg;

    // Fixed field widths.
    localparam int NF_W    = 24;
    localparam int DR_W    = 16;
    localparam int H_W     = 32;
    localparam int DRIVE_W = 32;
    localparam int OUT_W   = 48;
    localparam int CFG_W   = 32;
    localparam int PADDR_W = 4;

    // Multiply datapath widths.
    localparam int HALF_W  = 32;
    localparam int MAG_W   = 64;
    localparam int OPB_W   = 64;
    localparam int PROD_W  = 128;
    localparam int COEF_W  = 48;

    // Rounding shifts of the scaled products.
    localparam int RSH_28  = 28;
    localparam int RSH_32  = 32;
    localparam int RSH_33  = 33;
    localparam int RSH_DIV = 66;

    // Divide by six: floor(n/6) = (n * RECIP6) >> 66 for n below 2^65.
    // Rounding to nearest adds 3 to n, which is 3*RECIP6 = 2^65 + 1 ahead of the shift.
    localparam logic [OPB_W-1:0]  RECIP6    = 64'hAAAA_AAAA_AAAA_AAAB;
    localparam logic [PROD_W-1:0] DIV6_BIAS = 128'h2_0000_0000_0000_0001;

    // Register map, index = paddr[3:2].
    localparam logic [1:0] REG_NF = 2'd0;
    localparam logic [1:0] REG_DR = 2'd1;
    localparam logic [1:0] REG_H  = 2'd2;

    localparam logic [NF_W-1:0] NF_RESET = 24'd327680;
    localparam logic [DR_W-1:0] DR_RESET = 16'd6554;
    localparam logic [H_W-1:0]  H_RESET  = 32'd4294967;

    // Multiply unit modes.
    typedef enum logic [2:0] {
        MM_RAW,
        MM_R28,
        MM_R32,
        MM_R33,
        MM_DIV6
    } mul_mode_t;

    typedef enum logic [1:0] {
        UK_MUL,
        UK_ADD,
        UK_SUB
    } uop_kind_t;

    // Working registers and operand sources of the sequencer.
    typedef enum logic [3:0] {
        RS_P,
        RS_V,
        RS_U,
        RS_D,
        RS_X,
        RS_Y,
        RS_KV,
        RS_SP,
        RS_SV,
        RS_T,
        RS_NF,
        RS_DR,
        RS_ZERO,
        RS_CA,
        RS_CC
    } reg_sel_t;

    // Second multiply operand.
    typedef enum logic [1:0] {
        CS_CA,
        CS_CC,
        CS_H,
        CS_NF
    } coef_sel_t;

    typedef struct packed {
        uop_kind_t kind;
        mul_mode_t mode;
        reg_sel_t  dst;
        reg_sel_t  srca;
        reg_sel_t  srcb;
        coef_sel_t coef;
    } uop_t;

    localparam int         PC_W      = 6;
    localparam logic [5:0] PROG_LAST = 6'd48;

    function automatic uop_t mk_mul(mul_mode_t m, reg_sel_t d, reg_sel_t a, coef_sel_t c);
        uop_t op;
        op.kind = UK_MUL;
        op.mode = m;
        op.dst  = d;
        op.srca = a;
        op.srcb = RS_ZERO;
        op.coef = c;
        return op;
    endfunction

    function automatic uop_t mk_alu(uop_kind_t k, reg_sel_t d, reg_sel_t a, reg_sel_t b);
        uop_t op;
        op.kind = k;
        op.mode = MM_RAW;
        op.dst  = d;
        op.srca = a;
        op.srcb = b;
        op.coef = CS_H;
        return op;
    endfunction

    // One RK4 step. The drive term wn^2*u is formed once; the stage position
    // derivative is the stage velocity, so it is read straight from Y (or V).
    function automatic uop_t uop_rom(logic [PC_W-1:0] pc);
        uop_t op;
        case (pc)
            // Coefficients wn^2 and 2*zeta*wn, then the drive term wn^2*u.
            6'd0:  op = mk_mul(MM_RAW, RS_CA, RS_NF, CS_NF);
            6'd1:  op = mk_mul(MM_RAW, RS_CC, RS_DR, CS_NF);
            6'd2:  op = mk_mul(MM_R28, RS_D, RS_U, CS_CA);
            // k1 at (P, V).
            6'd3:  op = mk_mul(MM_R28, RS_T, RS_V, CS_CC);
            6'd4:  op = mk_alu(UK_SUB, RS_T, RS_D, RS_T);
            6'd5:  op = mk_mul(MM_R28, RS_KV, RS_P, CS_CA);
            6'd6:  op = mk_alu(UK_SUB, RS_KV, RS_T, RS_KV);
            6'd7:  op = mk_alu(UK_ADD, RS_SP, RS_V, RS_ZERO);
            6'd8:  op = mk_alu(UK_ADD, RS_SV, RS_KV, RS_ZERO);
            // Stage two input and k2.
            6'd9:  op = mk_mul(MM_R33, RS_X, RS_V, CS_H);
            6'd10: op = mk_alu(UK_ADD, RS_X, RS_P, RS_X);
            6'd11: op = mk_mul(MM_R33, RS_Y, RS_KV, CS_H);
            6'd12: op = mk_alu(UK_ADD, RS_Y, RS_V, RS_Y);
            6'd13: op = mk_mul(MM_R28, RS_T, RS_Y, CS_CC);
            6'd14: op = mk_alu(UK_SUB, RS_T, RS_D, RS_T);
            6'd15: op = mk_mul(MM_R28, RS_KV, RS_X, CS_CA);
            6'd16: op = mk_alu(UK_SUB, RS_KV, RS_T, RS_KV);
            6'd17: op = mk_alu(UK_ADD, RS_SP, RS_SP, RS_Y);
            6'd18: op = mk_alu(UK_ADD, RS_SP, RS_SP, RS_Y);
            6'd19: op = mk_alu(UK_ADD, RS_SV, RS_SV, RS_KV);
            6'd20: op = mk_alu(UK_ADD, RS_SV, RS_SV, RS_KV);
            // Stage three input and k3.
            6'd21: op = mk_mul(MM_R33, RS_X, RS_Y, CS_H);
            6'd22: op = mk_alu(UK_ADD, RS_X, RS_P, RS_X);
            6'd23: op = mk_mul(MM_R33, RS_Y, RS_KV, CS_H);
            6'd24: op = mk_alu(UK_ADD, RS_Y, RS_V, RS_Y);
            6'd25: op = mk_mul(MM_R28, RS_T, RS_Y, CS_CC);
            6'd26: op = mk_alu(UK_SUB, RS_T, RS_D, RS_T);
            6'd27: op = mk_mul(MM_R28, RS_KV, RS_X, CS_CA);
            6'd28: op = mk_alu(UK_SUB, RS_KV, RS_T, RS_KV);
            6'd29: op = mk_alu(UK_ADD, RS_SP, RS_SP, RS_Y);
            6'd30: op = mk_alu(UK_ADD, RS_SP, RS_SP, RS_Y);
            6'd31: op = mk_alu(UK_ADD, RS_SV, RS_SV, RS_KV);
            6'd32: op = mk_alu(UK_ADD, RS_SV, RS_SV, RS_KV);
            // Stage four input (full step) and k4.
            6'd33: op = mk_mul(MM_R32, RS_X, RS_Y, CS_H);
            6'd34: op = mk_alu(UK_ADD, RS_X, RS_P, RS_X);
            6'd35: op = mk_mul(MM_R32, RS_Y, RS_KV, CS_H);
            6'd36: op = mk_alu(UK_ADD, RS_Y, RS_V, RS_Y);
            6'd37: op = mk_mul(MM_R28, RS_T, RS_Y, CS_CC);
            6'd38: op = mk_alu(UK_SUB, RS_T, RS_D, RS_T);
            6'd39: op = mk_mul(MM_R28, RS_KV, RS_X, CS_CA);
            6'd40: op = mk_alu(UK_SUB, RS_KV, RS_T, RS_KV);
            6'd41: op = mk_alu(UK_ADD, RS_SP, RS_SP, RS_Y);
            6'd42: op = mk_alu(UK_ADD, RS_SV, RS_SV, RS_KV);
            // State update: x += round(round(h*S)/6).
            6'd43: op = mk_mul(MM_R32, RS_SP, RS_SP, CS_H);
            6'd44: op = mk_mul(MM_DIV6, RS_SP, RS_SP, CS_H);
            6'd45: op = mk_alu(UK_ADD, RS_P, RS_P, RS_SP);
            6'd46: op = mk_mul(MM_R32, RS_SV, RS_SV, CS_H);
            6'd47: op = mk_mul(MM_DIV6, RS_SV, RS_SV, CS_H);
            6'd48: op = mk_alu(UK_ADD, RS_V, RS_V, RS_SV);
            default: op = mk_alu(UK_ADD, RS_ZERO, RS_ZERO, RS_ZERO);
        endcase
        return op;
    endfunction

endpackage

// File: rtl/core/sop_rk4_mul.sv
// Shared multiply unit: signed operand times unsigned coefficient, with rounding,
// scaling shift and saturation. Depends on sop_rk4_pkg.
module sop_rk4_mul
    import sop_rk4_pkg::*;
#(
    parameter int STATE_WIDTH = 48
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  mul_mode_t                     mode,
    input  logic signed [STATE_WIDTH-1:0] opa,
    input  logic        [OPB_W-1:0]       opb,
    output logic                          done,
    output logic signed [STATE_WIDTH-1:0] result,
    output logic        [COEF_W-1:0]      product
);

    localparam logic [STATE_WIDTH-1:0] SMAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
    localparam logic [STATE_WIDTH-1:0] SMIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};

    logic                    busy_reg;
    logic                    done_reg;
    logic [2:0]              cnt_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic [OPB_W-1:0]        opb_reg;
    logic                    neg_reg;
    mul_mode_t               mode_reg;
    logic [PROD_W-1:0]       acc_reg;
    logic [2*HALF_W-1:0]     pp_reg;
    logic [1:0]              pp_pos_reg;

    logic [STATE_WIDTH-1:0]  opa_u;
    logic [STATE_WIDTH-1:0]  opa_mag;
    logic [PROD_W-1:0]       acc_init;
    logic [HALF_W-1:0]       a_chunk;
    logic [HALF_W-1:0]       b_chunk;
    logic [2*HALF_W-1:0]     pp_next;
    logic [PROD_W-1:0]       pp_shifted;
    logic [PROD_W-1:0]       quot;
    logic                    over;
    logic [STATE_WIDTH-1:0]  quot_lo;
    logic [STATE_WIDTH-1:0]  res_u;

    // Magnitude of the signed operand and the accumulator start value.
    always_comb
    begin
        opa_u   = unsigned'(opa);
        opa_mag = opa[STATE_WIDTH-1] ? (~opa_u + 1'b1) : opa_u;
        case (mode)
            MM_R28:  acc_init = PROD_W'(1) << (RSH_28 - 1);
            MM_R32:  acc_init = PROD_W'(1) << (RSH_32 - 1);
            MM_R33:  acc_init = PROD_W'(1) << (RSH_33 - 1);
            MM_DIV6: acc_init = DIV6_BIAS;
            default: acc_init = '0;
        endcase
    end

    // One 32x32 partial product per cycle, registered in pp_reg and then added into the accumulator.
    always_comb
    begin
        a_chunk = cnt_reg[1] ? mag_reg[MAG_W-1:HALF_W] : mag_reg[HALF_W-1:0];
        b_chunk = cnt_reg[0] ? opb_reg[OPB_W-1:HALF_W] : opb_reg[HALF_W-1:0];
        pp_next = a_chunk * b_chunk;
        case (pp_pos_reg)
            2'd0:    pp_shifted = PROD_W'(pp_reg);
            2'd1:    pp_shifted = PROD_W'(pp_reg) << HALF_W;
            default: pp_shifted = PROD_W'(pp_reg) << (2 * HALF_W);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == 3'd4)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg  <= MAG_W'(opa_mag);
            opb_reg  <= (mode == MM_DIV6) ? RECIP6 : opb;
            neg_reg  <= opa[STATE_WIDTH-1];
            mode_reg <= mode;
            acc_reg  <= acc_init;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 3'd4)
            begin
                pp_reg     <= pp_next;
                pp_pos_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
            end
            if (cnt_reg != 3'd0)
            begin
                acc_reg <= acc_reg + pp_shifted;
            end
        end
    end

    // Scale down, then rebuild the signed value with saturation.
    always_comb
    begin
        case (mode_reg)
            MM_R28:  quot = acc_reg >> RSH_28;
            MM_R32:  quot = acc_reg >> RSH_32;
            MM_R33:  quot = acc_reg >> RSH_33;
            MM_DIV6: quot = acc_reg >> RSH_DIV;
            default: quot = acc_reg;
        endcase
        over    = |quot[PROD_W-1:STATE_WIDTH-1];
        quot_lo = quot[STATE_WIDTH-1:0];
        if (over)
        begin
            res_u = neg_reg ? SMIN : SMAX;
        end
        else
        begin
            res_u = neg_reg ? (~quot_lo + 1'b1) : quot_lo;
        end
    end

    assign done    = done_reg;
    assign result  = signed'(res_u);
    assign product = acc_reg[COEF_W-1:0];

endmodule

// File: rtl/core/second_order_plant_rk4_step_core.sv
// Top level of the second-order plant RK4 step core: handshakes, register port,
// micro-program sequencer and saturating adder. Depends on sop_rk4_pkg and sop_rk4_mul.

// Each accepted word carries the plant drive u (signed Q8.24). The result word, which
// holds position and velocity as they stood before the step (signed Q24.24, the low
// 48 bits of the STATE_WIDTH-bit state), is presented the cycle after acceptance and
// the block then advances the state by one classical RK4 step of size h, saturating
// every intermediate at the state range. The step is a fixed micro-program of 49
// operations run on one shared multiply unit and one saturating adder: 21 multiplies
// (four 32x32 partial products through a single registered multiplier, plus issue
// and write-back) and 28 add or subtract operations retired in their issue cycle,
// so a new word is taken only once the step has ended and the result slot is free.
// Configuration registers at byte addresses 0 (natural_freq, Q10.14), 4 (damping_ratio,
// Q2.14) and 8 (step_size, Q0.32) may be written while the block is idle.
module second_order_plant_rk4_step_core
    import sop_rk4_pkg::*;
#(
    parameter int STATE_WIDTH = 48
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Input words.
    input  logic                      item_valid,
    output logic                      item_ready,
    input  logic signed [DRIVE_W-1:0] drive,
    // Result words.
    output logic                      result_valid,
    input  logic                      result_ready,
    output logic signed [OUT_W-1:0]   position,
    output logic signed [OUT_W-1:0]   velocity,
    // Register port.
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [CFG_W-1:0]          pwdata,
    output logic [CFG_W-1:0]          prdata,
    output logic                      pready
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;

    localparam logic signed [STATE_WIDTH-1:0] SMAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
    localparam logic signed [STATE_WIDTH-1:0] SMIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};

    // Configuration.
    logic [NF_W-1:0] nf_reg;
    logic [DR_W-1:0] dr_reg;
    logic [H_W-1:0]  h_reg;

    // Sequencer.
    logic [1:0]      state_reg;
    logic [1:0]      state_next;
    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    uop_t            uop;

    // Plant state and working registers.
    logic signed [STATE_WIDTH-1:0] p_reg;
    logic signed [STATE_WIDTH-1:0] v_reg;
    logic signed [STATE_WIDTH-1:0] u_reg;
    logic signed [STATE_WIDTH-1:0] d_reg;
    logic signed [STATE_WIDTH-1:0] x_reg;
    logic signed [STATE_WIDTH-1:0] y_reg;
    logic signed [STATE_WIDTH-1:0] kv_reg;
    logic signed [STATE_WIDTH-1:0] sp_reg;
    logic signed [STATE_WIDTH-1:0] sv_reg;
    logic signed [STATE_WIDTH-1:0] t_reg;
    logic [COEF_W-1:0]             ca_reg;
    logic [COEF_W-1:0]             cc_reg;

    // Result word.
    logic                          result_valid_reg;
    logic signed [OUT_W-1:0]       position_reg;
    logic signed [OUT_W-1:0]       velocity_reg;

    logic                          item_acc;
    logic                          cfg_wr;
    logic signed [STATE_WIDTH-1:0] opa;
    logic signed [STATE_WIDTH-1:0] opb;
    logic [OPB_W-1:0]              coef;
    logic signed [STATE_WIDTH:0]   alu_sum;
    logic signed [STATE_WIDTH-1:0] alu_res;
    logic                          mul_start;
    logic                          mul_done;
    logic signed [STATE_WIDTH-1:0] mul_res;
    logic [COEF_W-1:0]             mul_prod;
    logic                          wr_en;
    logic signed [STATE_WIDTH-1:0] wr_data;

    // Handshakes: a new word is taken only when idle and the result slot frees up.
    assign item_ready   = (state_reg == ST_IDLE) && (!result_valid_reg || result_ready);
    assign item_acc     = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign position     = position_reg;
    assign velocity     = velocity_reg;

    // Register port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_NF:  prdata = CFG_W'(nf_reg);
            REG_DR:  prdata = CFG_W'(dr_reg);
            REG_H:   prdata = CFG_W'(h_reg);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nf_reg <= NF_RESET;
            dr_reg <= DR_RESET;
            h_reg  <= H_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_NF:  nf_reg <= pwdata[NF_W-1:0];
                REG_DR:  dr_reg <= pwdata[DR_W-1:0];
                REG_H:   h_reg  <= pwdata[H_W-1:0];
                default: ;
            endcase
        end
    end

    // Current micro-operation.
    assign uop = uop_rom(pc_reg);

    // Operand selection.
    always_comb
    begin
        case (uop.srca)
            RS_P:    opa = p_reg;
            RS_V:    opa = v_reg;
            RS_U:    opa = u_reg;
            RS_D:    opa = d_reg;
            RS_X:    opa = x_reg;
            RS_Y:    opa = y_reg;
            RS_KV:   opa = kv_reg;
            RS_SP:   opa = sp_reg;
            RS_SV:   opa = sv_reg;
            RS_T:    opa = t_reg;
            RS_NF:   opa = signed'(STATE_WIDTH'(nf_reg));
            RS_DR:   opa = signed'(STATE_WIDTH'(dr_reg));
            default: opa = '0;
        endcase
        case (uop.srcb)
            RS_P:    opb = p_reg;
            RS_V:    opb = v_reg;
            RS_D:    opb = d_reg;
            RS_X:    opb = x_reg;
            RS_Y:    opb = y_reg;
            RS_KV:   opb = kv_reg;
            RS_SP:   opb = sp_reg;
            RS_SV:   opb = sv_reg;
            RS_T:    opb = t_reg;
            default: opb = '0;
        endcase
        case (uop.coef)
            CS_CA:   coef = OPB_W'(ca_reg);
            CS_CC:   coef = OPB_W'(cc_reg);
            CS_H:    coef = OPB_W'(h_reg);
            default: coef = OPB_W'(nf_reg);
        endcase
    end

    // Saturating add or subtract.
    always_comb
    begin
        if (uop.kind == UK_SUB)
        begin
            alu_sum = {opa[STATE_WIDTH-1], opa} - {opb[STATE_WIDTH-1], opb};
        end
        else
        begin
            alu_sum = {opa[STATE_WIDTH-1], opa} + {opb[STATE_WIDTH-1], opb};
        end
        if (alu_sum[STATE_WIDTH] != alu_sum[STATE_WIDTH-1])
        begin
            alu_res = alu_sum[STATE_WIDTH] ? SMIN : SMAX;
        end
        else
        begin
            alu_res = alu_sum[STATE_WIDTH-1:0];
        end
    end

    // Shared multiply unit.
    assign mul_start = (state_reg == ST_ISSUE) && (uop.kind == UK_MUL);

    sop_rk4_mul #(
        .STATE_WIDTH (STATE_WIDTH)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mode    (uop.mode),
        .opa     (opa),
        .opb     (coef),
        .done    (mul_done),
        .result  (mul_res),
        .product (mul_prod)
    );

    // Sequencer: adds retire in the issue cycle, multiplies on the unit's done.
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        wr_en      = 1'b0;
        wr_data    = alu_res;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    state_next = ST_ISSUE;
                    pc_next    = '0;
                end
            end
            ST_ISSUE:
            begin
                if (uop.kind == UK_MUL)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    wr_en = 1'b1;
                    if (pc_reg == PROG_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pc_next = pc_reg + 1'b1;
                    end
                end
            end
            ST_WAIT:
            begin
                wr_data = mul_res;
                if (mul_done)
                begin
                    wr_en = 1'b1;
                    if (pc_reg == PROG_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                        pc_next    = pc_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pc_reg           <= '0;
            result_valid_reg <= 1'b0;
            p_reg            <= '0;
            v_reg            <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            if (item_acc)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            if (wr_en && (uop.dst == RS_P))
            begin
                p_reg <= wr_data;
            end
            if (wr_en && (uop.dst == RS_V))
            begin
                v_reg <= wr_data;
            end
        end
    end

    // Working registers and the result word.
    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            u_reg        <= STATE_WIDTH'(drive);
            position_reg <= OUT_W'(p_reg);
            velocity_reg <= OUT_W'(v_reg);
        end
        if (wr_en)
        begin
            case (uop.dst)
                RS_D:    d_reg  <= wr_data;
                RS_X:    x_reg  <= wr_data;
                RS_Y:    y_reg  <= wr_data;
                RS_KV:   kv_reg <= wr_data;
                RS_SP:   sp_reg <= wr_data;
                RS_SV:   sv_reg <= wr_data;
                RS_T:    t_reg  <= wr_data;
                RS_CA:   ca_reg <= mul_prod;
                RS_CC:   cc_reg <= {mul_prod[COEF_W-2:0], 1'b0};
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/core/sop_rk4_chk.sv
// Port-level checker for the RK4 plant step core, bound to the top level.
// Depends on sop_rk4_pkg and second_order_plant_rk4_step_core.
module sop_rk4_chk
    import sop_rk4_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    item_valid,
    input logic                    item_ready,
    input logic                    result_valid,
    input logic                    result_ready,
    input logic signed [OUT_W-1:0] position,
    input logic signed [OUT_W-1:0] velocity
);

    // A stalled result word holds.
    ap_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(position) &&
        $stable(velocity))
        else $error("result word changed while stalled");

    // Every accepted word produces a result word on the next cycle.
    ap_result_next: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> result_valid)
        else $error("no result word after an accepted input word");

    // The step occupies the core, so it is busy right after an accept.
    ap_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("input ready right after an accept");

    // A new word is never taken while the previous result is stalled.
    ap_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !item_ready)
        else $error("input ready while a result word is stalled");

endmodule

bind second_order_plant_rk4_step_core sop_rk4_chk u_sop_rk4_chk (.*);
